FILE: hw/rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// OBB package
// Shared widths, types and lane helpers for the box overlap pipeline.
// ----------------------------------------------------------------------------
package obb_pkg;
	localparam int LaneW = 16;
	localparam int WordW = 48;
	localparam int CW = 19;
	localparam int TW = 33;
	localparam int RW = 40;
	localparam int PW = 56;
	localparam int AxisW = 4;
	localparam logic [AxisW-1:0] AxisNone = 4'd15;

	typedef logic signed [LaneW-1:0] lane_t;
	typedef logic signed [CW-1:0] cmat_t [3][3];
	typedef logic signed [TW-1:0] tvec_t [3];
	typedef logic [LaneW-2:0] ext_t [3];

	function automatic lane_t lane_of(input logic [WordW-1:0] w, input int idx);
		lane_of = lane_t'(w[idx*LaneW +: LaneW]);
	endfunction

	function automatic logic [LaneW-2:0] ext_of(input logic [WordW-1:0] w, input int idx);
		logic [LaneW-1:0] v;
		v = w[idx*LaneW +: LaneW];
		ext_of = v[LaneW-1] ? '0 : v[LaneW-2:0];
	endfunction
endpackage

FILE: hw/rtl/obb_products.sv
// ----------------------------------------------------------------------------
// OBB products stage
// Forms the relative rotation and both offset projections, registered.
// ----------------------------------------------------------------------------
module obb_products import obb_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [WordW-1:0]   rot_a [3],
	input  logic [WordW-1:0]   rot_b [3],
	input  logic [WordW-1:0]   offs,
	output cmat_t              c_s1,
	output tvec_t              ta_s1,
	output tvec_t              tb_s1
);
	logic signed [33:0] sc [3][3];
	logic signed [TW-1:0] sa [3];
	logic signed [TW-1:0] sb [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sa[i] = '0;
			sb[i] = '0;
			for (int k = 0; k < 3; k++) begin
				sa[i] = sa[i] + TW'(lane_of(rot_a[k], i)) * TW'(lane_of(offs, k));
				sb[i] = sb[i] + TW'(lane_of(rot_b[k], i)) * TW'(lane_of(offs, k));
			end
			for (int j = 0; j < 3; j++) begin
				sc[i][j] = '0;
				for (int k = 0; k < 3; k++)
					sc[i][j] = sc[i][j]
						+ 34'(lane_of(rot_a[k], i)) * 34'(lane_of(rot_b[k], j));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ta_s1[i] <= sa[i];
				tb_s1[i] <= sb[i];
				for (int j = 0; j < 3; j++)
					c_s1[i][j] <= CW'((sc[i][j] + 34'sd8192) >>> 14);
			end
		end
	end
endmodule

FILE: hw/rtl/obb_axes.sv
// ----------------------------------------------------------------------------
// OBB axis stage
// Computes radii and projections of all 15 axes into registers, then
// compares them and flags each separating axis.
// ----------------------------------------------------------------------------
module obb_axes import obb_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  cmat_t         c,
	input  tvec_t         ta,
	input  tvec_t         tb,
	input  ext_t          ea,
	input  ext_t          eb,
	output logic [14:0]   sep
);
	logic [CW-1:0] ac [3][3];
	logic [RW-1:0] r [15];
	logic signed [PW-1:0] p [15];
	logic [RW-1:0] r_s2 [15];
	logic signed [PW-1:0] p_s2 [15];
	logic [PW-1:0] ap;

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				ac[i][j] = c[i][j][CW-1] ? CW'(-c[i][j]) : CW'(c[i][j]);
		for (int i = 0; i < 3; i++) begin
			r[i] = (RW'(ea[i]) << 14) + RW'(eb[0]) * RW'(ac[i][0])
				+ RW'(eb[1]) * RW'(ac[i][1]) + RW'(eb[2]) * RW'(ac[i][2]);
			p[i] = PW'(ta[i]);
			r[3+i] = (RW'(eb[i]) << 14) + RW'(ea[0]) * RW'(ac[0][i])
				+ RW'(ea[1]) * RW'(ac[1][i]) + RW'(ea[2]) * RW'(ac[2][i]);
			p[3+i] = PW'(tb[i]);
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				r[6+3*i+j] = RW'(ea[(i+1)%3]) * RW'(ac[(i+2)%3][j])
					+ RW'(ea[(i+2)%3]) * RW'(ac[(i+1)%3][j])
					+ RW'(eb[(j+1)%3]) * RW'(ac[i][(j+2)%3])
					+ RW'(eb[(j+2)%3]) * RW'(ac[i][(j+1)%3]);
				p[6+3*i+j] = PW'(c[(i+1)%3][j]) * PW'(ta[(i+2)%3])
					- PW'(c[(i+2)%3][j]) * PW'(ta[(i+1)%3]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 15; k++) begin
				r_s2[k] <= r[k];
				p_s2[k] <= p[k];
			end
		end
	end

	always_comb begin
		sep = '0;
		ap = '0;
		for (int k = 0; k < 15; k++) begin
			ap = p_s2[k][PW-1] ? PW'(-p_s2[k]) : PW'(p_s2[k]);
			if (k < 6)
				sep[k] = PW'(r_s2[k]) < ap;
			else
				sep[k] = (PW'(r_s2[k]) << 14) < ap;
		end
	end
endmodule

FILE: hw/rtl/obb_overlap_test.sv
// ----------------------------------------------------------------------------
// OBB overlap test
// Separating axis test of two oriented boxes, one pair per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// A box pair word is accepted every cycle that the output is not stalled, and
// its result word passes through one register stage each for the products,
// then radii and projections, then the comparisons with a priority pick of
// the first separating axis. A stalled output freezes the whole pipeline and
// stalls the input in the same cycle.
module obb_overlap_test import obb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WordW-1:0] rot_a_row0,
	input  logic [WordW-1:0] rot_a_row1,
	input  logic [WordW-1:0] rot_a_row2,
	input  logic [WordW-1:0] rot_b_row0,
	input  logic [WordW-1:0] rot_b_row1,
	input  logic [WordW-1:0] rot_b_row2,
	input  logic [WordW-1:0] center_offset,
	input  logic [WordW-1:0] half_extent_a,
	input  logic [WordW-1:0] half_extent_b,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             boxes_overlap,
	output logic [AxisW-1:0] separating_axis
);
	logic v_s1, v_s2, v_s3, en;
	logic [WordW-1:0] rot_a [3];
	logic [WordW-1:0] rot_b [3];
	cmat_t c_s1;
	tvec_t ta_s1, tb_s1;
	ext_t ea_s1, eb_s1;
	logic [14:0] sep;
	logic [AxisW-1:0] axis;

	assign en = !out_stall;
	assign in_stall = out_stall;

	assign rot_a[0] = rot_a_row0;
	assign rot_a[1] = rot_a_row1;
	assign rot_a[2] = rot_a_row2;
	assign rot_b[0] = rot_b_row0;
	assign rot_b[1] = rot_b_row1;
	assign rot_b[2] = rot_b_row2;

	obb_products u_prod (
		.clk(clk), .en(en),
		.rot_a(rot_a),
		.rot_b(rot_b),
		.offs(center_offset),
		.c_s1(c_s1), .ta_s1(ta_s1), .tb_s1(tb_s1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ea_s1[i] <= ext_of(half_extent_a, i);
				eb_s1[i] <= ext_of(half_extent_b, i);
			end
		end
	end

	obb_axes u_axes (
		.clk(clk), .en(en), .c(c_s1), .ta(ta_s1), .tb(tb_s1),
		.ea(ea_s1), .eb(eb_s1), .sep(sep)
	);

	always_comb begin
		axis = AxisNone;
		for (int k = 14; k >= 0; k--)
			if (sep[k])
				axis = AxisW'(k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			separating_axis <= axis;
			boxes_overlap <= axis == AxisNone;
		end
	end

	assign out_valid = v_s3;
endmodule

FILE: hw/rtl/obb_checker.sv
// ----------------------------------------------------------------------------
// OBB checker
// Port-level checks of the overlap test, bound to the top level.
// ----------------------------------------------------------------------------
module obb_checker import obb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic             boxes_overlap,
	input logic [AxisW-1:0] separating_axis
);
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (boxes_overlap == (separating_axis == AxisNone))) else $error("flag");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("latency");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(separating_axis))
		else $error("hold");
endmodule

bind obb_overlap_test obb_checker u_chk (.*);
